// ----- src/ovs_uart_pkg.sv -----
// ---------------------------------------------------------------------------
// ovs_uart_pkg
// Shared codes, widths and constants of the oversampled UART transceiver.
// ---------------------------------------------------------------------------
package ovs_uart_pkg;

	// Field widths of the request and result channels
	localparam int KIND_W = 3;
	localparam int BYTE_W = 8;
	localparam int FLAG_IDX_W = 2;
	localparam int FLAG_W = 4;
	localparam int BIT_IDX_W = 3;
	localparam int BIT_CNT_W = 4;
	localparam int PHASE_W = 3;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [FLAG_IDX_W-1:0] flag_idx_t;
	typedef logic [FLAG_W-1:0] flag_vec_t;
	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [BIT_CNT_W-1:0] bit_cnt_t;
	typedef logic [BIT_IDX_W-1:0] bit_idx_t;

	// Request kinds
	localparam kind_t KIND_TICK = 3'd0;
	localparam kind_t KIND_WRITE = 3'd1;
	localparam kind_t KIND_READ = 3'd2;
	localparam kind_t KIND_PEEK = 3'd3;
	localparam kind_t KIND_RX_EN = 3'd4;
	localparam kind_t KIND_ABORT_TX = 3'd5;
	localparam kind_t KIND_ABORT_RX = 3'd6;
	localparam kind_t KIND_CLR_FLAG = 3'd7;

	// Flag bit positions
	localparam int FLAG_TX_EMPTY = 0;
	localparam int FLAG_RX_BYTE = 1;
	localparam int FLAG_RX_FULL = 2;
	localparam int FLAG_TX_FULL = 3;

	// Oversampling and framing
	localparam phase_t PHASE_LAST = 3'd4;
	localparam phase_t SAMPLE_OFFSET = 3'd2;
	localparam phase_t TX_PHASE = 3'd0;
	localparam bit_cnt_t STOP_BIT = 4'd9;

	// How the transmit line is set by one request
	typedef logic [1:0] line_mode_t;
	localparam line_mode_t LINE_HOLD = 2'd0;
	localparam line_mode_t LINE_LOW = 2'd1;
	localparam line_mode_t LINE_HIGH = 2'd2;
	localparam line_mode_t LINE_DATA = 2'd3;

	localparam int DEFAULT_FIFO_DEPTH = 64;

endpackage

// ----- src/ovs_uart_if.sv -----
// ---------------------------------------------------------------------------
// ovs_uart_in_if / ovs_uart_out_if
// Valid/ready channels for host requests and their results.
// ---------------------------------------------------------------------------
interface ovs_uart_in_if;
	import ovs_uart_pkg::*;

	logic valid;
	logic ready;
	kind_t kind;
	logic rx_level;
	byte_t tx_byte;
	logic rx_enable_value;
	flag_idx_t flag_index;

	modport source (output valid, kind, rx_level, tx_byte, rx_enable_value, flag_index,
		input ready);
	modport sink (input valid, kind, rx_level, tx_byte, rx_enable_value, flag_index,
		output ready);
endinterface

interface ovs_uart_out_if #(
	parameter int DEPTH = ovs_uart_pkg::DEFAULT_FIFO_DEPTH
);
	import ovs_uart_pkg::*;

	localparam int FILL_W = $clog2(DEPTH + 1);

	logic valid;
	logic ready;
	logic tx_line;
	byte_t rx_data;
	logic rx_data_valid;
	logic write_accepted;
	logic [FILL_W-1:0] rx_fill;
	logic [FILL_W-1:0] tx_fill;
	logic tx_busy;
	flag_vec_t flag_bits;

	modport source (output valid, tx_line, rx_data, rx_data_valid, write_accepted, rx_fill,
		tx_fill, tx_busy, flag_bits, input ready);
	modport sink (input valid, tx_line, rx_data, rx_data_valid, write_accepted, rx_fill,
		tx_fill, tx_busy, flag_bits, output ready);
endinterface

// ----- src/ovs_uart_ram.sv -----
// ---------------------------------------------------------------------------
// ovs_uart_ram
// Byte store for one FIFO: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ovs_uart_ram #(
	parameter int DEPTH = ovs_uart_pkg::DEFAULT_FIFO_DEPTH,
	parameter int WIDTH = ovs_uart_pkg::BYTE_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read one entry; hold the data while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- src/oversampled_uart_transceiver.sv -----
// ---------------------------------------------------------------------------
// oversampled_uart_transceiver
// One 8N1 UART port clocked by tick requests at five times the baud rate,
// with receive and transmit byte FIFOs held in synchronous memories.
// ---------------------------------------------------------------------------
//  channel | dir | handshake    | carries
//  req     | in  | valid/ready  | kind, rx_level, tx_byte, rx_enable_value, flag_index
//  rsp     | out | valid/ready  | tx_line, rx_data, rx_data_valid, write_accepted,
//          |     |              | rx_fill, tx_fill, tx_busy, flag_bits
//
// One request per cycle while ready is high; each result is built in steps:
// control state updates at acceptance, the FIFO memory read lands in stage 1,
// and the result register is stage 2.
// Reset clears all control state and drives the line high; FIFO memories are
// not cleared, their contents are valid only where written.
// Stage 1 keeps taking requests while a result waits; ready drops only when
// stage 1 and the result register are both full and the result is not taken.
// ---------------------------------------------------------------------------
module oversampled_uart_transceiver #(
	parameter int FIFO_DEPTH = ovs_uart_pkg::DEFAULT_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	ovs_uart_in_if.sink req,
	ovs_uart_out_if.source rsp
);
	import ovs_uart_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

	// Control state
	phase_t tick_phase_q, sample_phase_q;
	logic phase_locked_q;
	bit_cnt_t rx_bit_count_q;
	byte_t rx_shift_q;
	logic rx_on_q;
	logic [PTR_W-1:0] rx_read_ptr_q, rx_write_ptr_q;
	logic [CNT_W-1:0] rx_count_q;
	logic [PTR_W-1:0] tx_read_ptr_q, tx_write_ptr_q;
	logic [CNT_W-1:0] tx_count_q;
	bit_cnt_t tx_bit_count_q;
	logic tx_on_q, tx_pending_q;
	logic line_q;
	flag_vec_t flags_q;

	// Next state
	phase_t tick_phase_n, sample_phase_n;
	logic phase_locked_n;
	bit_cnt_t rx_bit_count_n;
	byte_t rx_shift_n;
	logic rx_on_n;
	logic [PTR_W-1:0] rx_read_ptr_n, rx_write_ptr_n;
	logic [CNT_W-1:0] rx_count_n;
	logic [PTR_W-1:0] tx_read_ptr_n, tx_write_ptr_n;
	logic [CNT_W-1:0] tx_count_n;
	bit_cnt_t tx_bit_count_n;
	logic tx_on_n, tx_pending_n;
	flag_vec_t flags_n;

	// Per-request results
	logic rx_push, tx_push, data_valid, accepted;
	line_mode_t line_mode;
	bit_idx_t bit_idx;

	// Pipeline control
	logic in_fire, s1_free, out_adv;
	logic valid_s1, valid_s2;

	// Stage 1 registers
	logic data_valid_s1, accepted_s1, busy_s1;
	logic [CNT_W-1:0] rx_fill_s1, tx_fill_s1;
	flag_vec_t flags_s1;
	line_mode_t line_mode_s1;
	bit_idx_t bit_idx_s1;
	byte_t rx_rdata_s1, tx_rdata_s1;
	logic line_s1;

	// Stage 2 registers
	logic line_s2, data_valid_s2, accepted_s2, busy_s2;
	byte_t rx_data_s2;
	logic [CNT_W-1:0] rx_fill_s2, tx_fill_s2;
	flag_vec_t flags_s2;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// Handshake
	assign out_adv = !valid_s2 || rsp.ready;
	assign s1_free = !valid_s1 || out_adv;
	assign req.ready = s1_free;
	assign in_fire = req.valid && s1_free;

	// Compute the state update of one request
	always_comb begin
		tick_phase_n = tick_phase_q;
		sample_phase_n = sample_phase_q;
		phase_locked_n = phase_locked_q;
		rx_bit_count_n = rx_bit_count_q;
		rx_shift_n = rx_shift_q;
		rx_on_n = rx_on_q;
		rx_read_ptr_n = rx_read_ptr_q;
		rx_write_ptr_n = rx_write_ptr_q;
		rx_count_n = rx_count_q;
		tx_read_ptr_n = tx_read_ptr_q;
		tx_write_ptr_n = tx_write_ptr_q;
		tx_count_n = tx_count_q;
		tx_bit_count_n = tx_bit_count_q;
		tx_on_n = tx_on_q;
		tx_pending_n = tx_pending_q;
		flags_n = flags_q;
		rx_push = 1'b0;
		tx_push = 1'b0;
		data_valid = 1'b0;
		accepted = 1'b0;
		line_mode = LINE_HOLD;
		bit_idx = '0;

		unique case (req.kind) inside
			KIND_TICK: begin
				// Lock the sampling phase when the line is low while hunting
				if (rx_bit_count_q == '0 && !phase_locked_q && !req.rx_level) begin
					sample_phase_n = (tick_phase_q > PHASE_LAST - SAMPLE_OFFSET)
						? tick_phase_q - (PHASE_LAST + 3'd1 - SAMPLE_OFFSET)
						: tick_phase_q + SAMPLE_OFFSET;
					phase_locked_n = 1'b1;
				end
				// Receive one bit at the sampling phase
				if (sample_phase_n == tick_phase_q && rx_on_q) begin
					if (rx_bit_count_q == '0) begin
						if (req.rx_level) begin
							phase_locked_n = 1'b0;
						end else begin
							rx_shift_n = '0;
							rx_bit_count_n = 4'd1;
						end
					end else if (rx_bit_count_q < STOP_BIT) begin
						rx_shift_n = rx_shift_q
							| (BYTE_W'(req.rx_level) << BIT_IDX_W'(rx_bit_count_q - 4'd1));
						rx_bit_count_n = rx_bit_count_q + 4'd1;
					end else begin
						rx_bit_count_n = '0;
						phase_locked_n = 1'b0;
						if (rx_bit_count_q == STOP_BIT && req.rx_level) begin
							if (rx_count_q < CNT_FULL) begin
								rx_push = 1'b1;
								rx_write_ptr_n = next_ptr(rx_write_ptr_q);
								rx_count_n = rx_count_q + 1'b1;
								flags_n[FLAG_RX_BYTE] = 1'b1;
							end else begin
								flags_n[FLAG_RX_FULL] = 1'b1;
							end
						end
					end
				end
				// Transmit one bit on the transmit phase
				if (tick_phase_q == TX_PHASE && tx_on_q) begin
					if (tx_bit_count_q == '0) begin
						tx_pending_n = 1'b1;
						line_mode = LINE_LOW;
						tx_bit_count_n = 4'd1;
					end else if (tx_bit_count_q < STOP_BIT) begin
						line_mode = LINE_DATA;
						bit_idx = BIT_IDX_W'(tx_bit_count_q - 4'd1);
						tx_bit_count_n = tx_bit_count_q + 4'd1;
					end else begin
						line_mode = LINE_HIGH;
						tx_bit_count_n = '0;
						tx_read_ptr_n = next_ptr(tx_read_ptr_q);
						if (tx_count_q != '0) begin
							tx_count_n = tx_count_q - 1'b1;
						end
						if (tx_count_n != '0) begin
							tx_pending_n = 1'b1;
							tx_on_n = 1'b1;
						end else begin
							tx_pending_n = 1'b0;
							tx_on_n = 1'b0;
							flags_n[FLAG_TX_EMPTY] = 1'b1;
						end
					end
				end
				tick_phase_n = (tick_phase_q == PHASE_LAST) ? '0 : tick_phase_q + 3'd1;
			end
			KIND_WRITE: begin
				if (tx_count_q >= CNT_FULL) begin
					flags_n[FLAG_TX_FULL] = 1'b1;
				end else begin
					tx_push = 1'b1;
					tx_write_ptr_n = next_ptr(tx_write_ptr_q);
					tx_count_n = tx_count_q + 1'b1;
					tx_pending_n = 1'b1;
					tx_on_n = 1'b1;
					accepted = 1'b1;
				end
			end
			KIND_READ, KIND_PEEK: begin
				if (rx_count_q != '0) begin
					data_valid = 1'b1;
					if (req.kind == KIND_READ) begin
						rx_read_ptr_n = next_ptr(rx_read_ptr_q);
						rx_count_n = rx_count_q - 1'b1;
					end
				end
			end
			KIND_RX_EN: begin
				rx_on_n = req.rx_enable_value;
			end
			KIND_ABORT_TX: begin
				if (tx_on_q) begin
					tx_on_n = 1'b0;
					tx_pending_n = 1'b0;
					tx_read_ptr_n = '0;
					tx_write_ptr_n = '0;
					tx_count_n = '0;
					tx_bit_count_n = '0;
					line_mode = LINE_HIGH;
					flags_n[FLAG_TX_FULL] = 1'b0;
					flags_n[FLAG_TX_EMPTY] = 1'b1;
				end
			end
			KIND_ABORT_RX: begin
				if (rx_on_q) begin
					rx_on_n = 1'b0;
					phase_locked_n = 1'b0;
					sample_phase_n = '0;
					rx_read_ptr_n = '0;
					rx_write_ptr_n = '0;
					rx_count_n = '0;
					rx_shift_n = '0;
					rx_bit_count_n = '0;
					flags_n[FLAG_RX_FULL] = 1'b0;
					flags_n[FLAG_RX_BYTE] = 1'b0;
				end
			end
			KIND_CLR_FLAG: begin
				flags_n[req.flag_index] = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Commit control state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_phase_q <= '0;
			sample_phase_q <= '0;
			phase_locked_q <= 1'b0;
			rx_bit_count_q <= '0;
			rx_shift_q <= '0;
			rx_on_q <= 1'b0;
			rx_read_ptr_q <= '0;
			rx_write_ptr_q <= '0;
			rx_count_q <= '0;
			tx_read_ptr_q <= '0;
			tx_write_ptr_q <= '0;
			tx_count_q <= '0;
			tx_bit_count_q <= '0;
			tx_on_q <= 1'b0;
			tx_pending_q <= 1'b0;
			flags_q <= '0;
		end else if (in_fire) begin
			tick_phase_q <= tick_phase_n;
			sample_phase_q <= sample_phase_n;
			phase_locked_q <= phase_locked_n;
			rx_bit_count_q <= rx_bit_count_n;
			rx_shift_q <= rx_shift_n;
			rx_on_q <= rx_on_n;
			rx_read_ptr_q <= rx_read_ptr_n;
			rx_write_ptr_q <= rx_write_ptr_n;
			rx_count_q <= rx_count_n;
			tx_read_ptr_q <= tx_read_ptr_n;
			tx_write_ptr_q <= tx_write_ptr_n;
			tx_count_q <= tx_count_n;
			tx_bit_count_q <= tx_bit_count_n;
			tx_on_q <= tx_on_n;
			tx_pending_q <= tx_pending_n;
			flags_q <= flags_n;
		end
	end

	// FIFO memories; each read targets the head entry before this request
	ovs_uart_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(BYTE_W)) u_rx_ram (
		.clk   (clk),
		.we    (in_fire && rx_push),
		.waddr (rx_write_ptr_q),
		.wdata (rx_shift_q),
		.re    (in_fire),
		.raddr (rx_read_ptr_q),
		.rdata (rx_rdata_s1)
	);

	ovs_uart_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(BYTE_W)) u_tx_ram (
		.clk   (clk),
		.we    (in_fire && tx_push),
		.waddr (tx_write_ptr_q),
		.wdata (req.tx_byte),
		.re    (in_fire),
		.raddr (tx_read_ptr_q),
		.rdata (tx_rdata_s1)
	);

	// Stage 1 valid and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (out_adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_valid_s1 <= data_valid;
			accepted_s1 <= accepted;
			busy_s1 <= tx_pending_n;
			rx_fill_s1 <= rx_count_n;
			tx_fill_s1 <= tx_count_n;
			flags_s1 <= flags_n;
			line_mode_s1 <= line_mode;
			bit_idx_s1 <= bit_idx;
		end
	end

	// Resolve the line level of the request in stage 1
	always_comb begin
		case (line_mode_s1)
			LINE_LOW:  line_s1 = 1'b0;
			LINE_HIGH: line_s1 = 1'b1;
			LINE_DATA: line_s1 = tx_rdata_s1[bit_idx_s1];
			default:   line_s1 = line_q;
		endcase
	end

	// Track the line level as results move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= 1'b1;
		end else if (valid_s1 && out_adv) begin
			line_q <= line_s1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (valid_s1 && out_adv) begin
			line_s2 <= line_s1;
			rx_data_s2 <= data_valid_s1 ? rx_rdata_s1 : '0;
			data_valid_s2 <= data_valid_s1;
			accepted_s2 <= accepted_s1;
			rx_fill_s2 <= rx_fill_s1;
			tx_fill_s2 <= tx_fill_s1;
			busy_s2 <= busy_s1;
			flags_s2 <= flags_s1;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.tx_line = line_s2;
	assign rsp.rx_data = rx_data_s2;
	assign rsp.rx_data_valid = data_valid_s2;
	assign rsp.write_accepted = accepted_s2;
	assign rsp.rx_fill = rx_fill_s2;
	assign rsp.tx_fill = tx_fill_s2;
	assign rsp.tx_busy = busy_s2;
	assign rsp.flag_bits = flags_s2;

	// FIFO counts never pass the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= CNT_FULL && tx_count_q <= CNT_FULL)
		else $error("FIFO count beyond depth");

	// Transmitter enable and busy move together
	a_tx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tx_on_q == tx_pending_q)
		else $error("tx busy out of step with tx enable");

	// An empty receive FIFO has matching pointers
	a_rx_empty_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q == '0 |-> rx_read_ptr_q == rx_write_ptr_q)
		else $error("rx pointers differ on empty FIFO");

	// A stalled result keeps stage 1 occupied
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !rsp.ready |=> valid_s1)
		else $error("stage 1 dropped a request under stall");
endmodule

// ----- dv/tb_uart_sb_pkg.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_uart_sb_pkg
// Request and status types plus the scoreboard of the UART transceiver
// bench: it follows the port state per accepted request and checks each
// returned status word against the oldest one it has worked out.
// ---------------------------------------------------------------------------
package tb_uart_sb_pkg;
	import ovs_uart_pkg::*;

	localparam int DEPTH = DEFAULT_FIFO_DEPTH;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int NUM_PHASES = PHASE_LAST + 1;

	typedef logic [FILL_W-1:0] fill_t;

	typedef struct {
		kind_t kind;
		logic rx_level;
		byte_t tx_byte;
		logic rx_enable_value;
		flag_idx_t flag_index;
	} uart_req_t;

	typedef struct {
		logic tx_line;
		byte_t rx_data;
		logic rx_data_valid;
		logic write_accepted;
		fill_t rx_fill;
		fill_t tx_fill;
		logic tx_busy;
		flag_vec_t flag_bits;
	} uart_status_t;

	class uart_scoreboard;
		// receive side
		phase_t tick_ph;
		phase_t samp_ph;
		logic locked;
		bit_cnt_t rx_cnt;
		byte_t rx_sh;
		logic rx_en;
		byte_t rx_mem [DEPTH];
		int rx_rd, rx_wr, rx_num;
		// transmit side
		byte_t tx_mem [DEPTH];
		int tx_rd, tx_wr, tx_num;
		bit_cnt_t tx_cnt;
		logic tx_en, tx_pend, line;
		flag_vec_t flg;

		uart_status_t status_q[$];
		int errors;

		function new();
			tick_ph = '0;
			samp_ph = '0;
			locked = 1'b0;
			rx_cnt = '0;
			rx_sh = '0;
			rx_en = 1'b0;
			rx_rd = 0;
			rx_wr = 0;
			rx_num = 0;
			tx_rd = 0;
			tx_wr = 0;
			tx_num = 0;
			tx_cnt = '0;
			tx_en = 1'b0;
			tx_pend = 1'b0;
			line = 1'b1;
			flg = '0;
			errors = 0;
		endfunction

		// Feed one sampled bit to the frame receiver
		function void rx_sample(logic b);
			logic good;
			if (!rx_en)
				return;
			if (rx_cnt == 0) begin
				if (b) begin
					// false start: go back to hunting an edge
					locked = 1'b0;
					return;
				end
				rx_sh = '0;
				rx_cnt = 4'd1;
			end else if (rx_cnt < STOP_BIT) begin
				rx_sh[rx_cnt - 4'd1] = b;
				rx_cnt = rx_cnt + 4'd1;
			end else begin
				good = (rx_cnt == STOP_BIT) && b;
				rx_cnt = '0;
				locked = 1'b0;
				if (good) begin
					if (rx_num < DEPTH) begin
						rx_mem[rx_wr] = rx_sh;
						rx_wr = (rx_wr + 1) % DEPTH;
						rx_num++;
						flg[FLAG_RX_BYTE] = 1'b1;
					end else begin
						flg[FLAG_RX_FULL] = 1'b1;
					end
				end
			end
		endfunction

		// Drive one bit of the byte at the head of the transmit store
		function void tx_drive();
			if (!tx_en)
				return;
			if (tx_cnt == 0) begin
				tx_pend = 1'b1;
				line = 1'b0;
				tx_cnt = 4'd1;
			end else if (tx_cnt < STOP_BIT) begin
				line = tx_mem[tx_rd][tx_cnt - 4'd1];
				tx_cnt = tx_cnt + 4'd1;
			end else begin
				line = 1'b1;
				tx_cnt = '0;
				tx_rd = (tx_rd + 1) % DEPTH;
				if (tx_num > 0)
					tx_num--;
				if (tx_num > 0) begin
					tx_pend = 1'b1;
					tx_en = 1'b1;
				end else begin
					tx_pend = 1'b0;
					tx_en = 1'b0;
					flg[FLAG_TX_EMPTY] = 1'b1;
				end
			end
		endfunction

		// Advance the oversampling phase by one tick
		function void tick(logic lvl);
			if (rx_cnt == 0 && !locked && !lvl) begin
				samp_ph = phase_t'((int'(tick_ph) + int'(SAMPLE_OFFSET)) % NUM_PHASES);
				locked = 1'b1;
			end
			if (samp_ph == tick_ph)
				rx_sample(lvl);
			if (tick_ph == TX_PHASE)
				tx_drive();
			tick_ph = (tick_ph == PHASE_LAST) ? phase_t'(0) : phase_t'(tick_ph + 3'd1);
		endfunction

		// Apply one accepted request and queue the status it yields
		function void note_request(uart_req_t r);
			uart_status_t s;
			s.rx_data = '0;
			s.rx_data_valid = 1'b0;
			s.write_accepted = 1'b0;
			case (r.kind) inside
				KIND_TICK: begin
					tick(r.rx_level);
				end
				KIND_WRITE: begin
					if (tx_num >= DEPTH) begin
						flg[FLAG_TX_FULL] = 1'b1;
					end else begin
						tx_mem[tx_wr] = r.tx_byte;
						tx_wr = (tx_wr + 1) % DEPTH;
						tx_num++;
						tx_pend = 1'b1;
						tx_en = 1'b1;
						s.write_accepted = 1'b1;
					end
				end
				KIND_READ, KIND_PEEK: begin
					if (rx_num > 0) begin
						s.rx_data = rx_mem[rx_rd];
						s.rx_data_valid = 1'b1;
						if (r.kind == KIND_READ) begin
							rx_rd = (rx_rd + 1) % DEPTH;
							rx_num--;
						end
					end
				end
				KIND_RX_EN: begin
					rx_en = r.rx_enable_value;
				end
				KIND_ABORT_TX: begin
					if (tx_en) begin
						tx_en = 1'b0;
						tx_pend = 1'b0;
						tx_rd = 0;
						tx_wr = 0;
						tx_num = 0;
						tx_cnt = '0;
						line = 1'b1;
						flg[FLAG_TX_FULL] = 1'b0;
						flg[FLAG_TX_EMPTY] = 1'b1;
					end
				end
				KIND_ABORT_RX: begin
					if (rx_en) begin
						rx_en = 1'b0;
						locked = 1'b0;
						samp_ph = '0;
						rx_rd = 0;
						rx_wr = 0;
						rx_num = 0;
						rx_sh = '0;
						rx_cnt = '0;
						flg[FLAG_RX_FULL] = 1'b0;
						flg[FLAG_RX_BYTE] = 1'b0;
					end
				end
				default: begin
					flg[r.flag_index] = 1'b0;
				end
			endcase
			s.tx_line = line;
			s.rx_fill = fill_t'(rx_num);
			s.tx_fill = fill_t'(tx_num);
			s.tx_busy = tx_pend;
			s.flag_bits = flg;
			status_q.push_back(s);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 100)
				$display("ERROR [status] %s", what);
		endtask

		task compare_field(string name, logic [31:0] g, logic [31:0] e);
			if (g !== e)
				report_mismatch($sformatf("%s got %0h exp %0h", name, g, e));
		endtask

		// Compare a returned status word with the oldest one outstanding
		task check_status(uart_status_t got);
			uart_status_t exp;
			if (status_q.size() == 0) begin
				report_mismatch("status word with no request outstanding");
				return;
			end
			exp = status_q.pop_front();
			compare_field("tx_line", 32'(got.tx_line), 32'(exp.tx_line));
			compare_field("rx_data", 32'(got.rx_data), 32'(exp.rx_data));
			compare_field("rx_data_valid", 32'(got.rx_data_valid), 32'(exp.rx_data_valid));
			compare_field("write_accepted", 32'(got.write_accepted), 32'(exp.write_accepted));
			compare_field("rx_fill", 32'(got.rx_fill), 32'(exp.rx_fill));
			compare_field("tx_fill", 32'(got.tx_fill), 32'(exp.tx_fill));
			compare_field("tx_busy", 32'(got.tx_busy), 32'(exp.tx_busy));
			compare_field("flag_bits", 32'(got.flag_bits), 32'(exp.flag_bits));
		endtask
	endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Bench for the oversampled UART transceiver: drives ticks carrying whole
// receive frames, noise and host requests through the request channel under
// several idle and stall patterns, and checks every status word in order.
// ---------------------------------------------------------------------------
module tb_top;
	import ovs_uart_pkg::*;
	import tb_uart_sb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 160;
	localparam int RX_BURST = 6;

	logic clk;
	logic arst_n;

	ovs_uart_in_if req_ch ();
	ovs_uart_out_if #(.DEPTH(DEPTH)) rsp_ch ();

	oversampled_uart_transceiver #(
		.FIFO_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	uart_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int issued = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one request, idling first at random, and hold it until taken
	task automatic issue(kind_t k, logic lvl, byte_t b, logic en, flag_idx_t f);
		uart_req_t r;
		r.kind = k;
		r.rx_level = lvl;
		r.tx_byte = b;
		r.rx_enable_value = en;
		r.flag_index = f;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.rx_level <= lvl;
		req_ch.tx_byte <= b;
		req_ch.rx_enable_value <= en;
		req_ch.flag_index <= f;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
		issued++;
	endtask

	task automatic host(kind_t k);
		issue(k, 1'($urandom), byte_t'($urandom), 1'($urandom), flag_idx_t'($urandom));
	endtask

	task automatic tick(logic lvl);
		issue(KIND_TICK, lvl, byte_t'($urandom), 1'($urandom), flag_idx_t'($urandom));
	endtask

	task automatic write_byte(byte_t b);
		issue(KIND_WRITE, 1'($urandom), b, 1'($urandom), flag_idx_t'($urandom));
	endtask

	task automatic set_rx_enable(logic en);
		issue(KIND_RX_EN, 1'($urandom), byte_t'($urandom), en, flag_idx_t'($urandom));
	endtask

	task automatic idle_ticks(int n);
		repeat (n) tick(1'b1);
	endtask

	// Play one 8N1 frame on the receive line, five ticks per bit
	task automatic send_frame(byte_t d, logic stop_lvl, int stop_ticks);
		logic [8:0] bits;
		bits = {d, 1'b0};
		for (int i = 0; i < 9; i++)
			repeat (5) tick(bits[i]);
		repeat (stop_ticks) tick(stop_lvl);
	endtask

	// Queue a burst of received frames, peek, then read one past empty
	task automatic fill_rx_store();
		set_rx_enable(1'b1);
		idle_ticks(50);
		repeat (RX_BURST) send_frame(byte_t'($urandom), 1'b1, 3);
		host(KIND_PEEK);
		repeat (RX_BURST + 1) host(KIND_READ);
	endtask

	// Mostly well-formed frames, with host traffic and noise mixed in
	task automatic random_mix(int target);
		int start;
		int pick;
		start = issued;
		while (issued - start < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				if (!sb.rx_en && $urandom_range(0, 7) != 0)
					set_rx_enable(1'b1);
				idle_ticks($urandom_range(0, 7));
				send_frame(byte_t'($urandom), $urandom_range(0, 9) != 0, $urandom_range(3, 8));
			end else if (pick < 50) begin
				idle_ticks($urandom_range(1, 40));
			end else if (pick < 55) begin
				// glitches, then settle so the next frame starts clean
				repeat ($urandom_range(1, 6)) tick(1'($urandom));
				idle_ticks(50);
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 4)) write_byte(byte_t'($urandom));
			end else if (pick < 83) begin
				repeat ($urandom_range(1, 4))
					host(($urandom_range(0, 1) != 0) ? KIND_READ : KIND_PEEK);
			end else if (pick < 88) begin
				set_rx_enable($urandom_range(0, 3) != 0);
			end else if (pick < 92) begin
				host(KIND_ABORT_TX);
			end else if (pick < 95) begin
				host(KIND_ABORT_RX);
			end else begin
				host(KIND_CLR_FLAG);
			end
		end
	endtask

	// Receiver side: random stalls, or one long hold-off on request
	initial begin
		int n;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				rsp_ch.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Check each status word taken from the block
	initial begin
		uart_status_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.tx_line = rsp_ch.tx_line;
				got.rx_data = rsp_ch.rx_data;
				got.rx_data_valid = rsp_ch.rx_data_valid;
				got.write_accepted = rsp_ch.write_accepted;
				got.rx_fill = rsp_ch.rx_fill;
				got.tx_fill = rsp_ch.tx_fill;
				got.tx_busy = rsp_ch.tx_busy;
				got.flag_bits = rsp_ch.flag_bits;
				sb.check_status(got);
			end
		end
	end

	// Stop a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_TICK;
		req_ch.rx_level <= 1'b1;
		req_ch.tx_byte <= '0;
		req_ch.rx_enable_value <= 1'b0;
		req_ch.flag_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty reads and aborts with both sides idle
		host(KIND_PEEK);
		host(KIND_READ);
		host(KIND_ABORT_TX);
		host(KIND_ABORT_RX);
		// lock follows the line while the receiver is off
		tick(1'b0);
		tick(1'b0);
		tick(1'b1);
		tick(1'b1);
		tick(1'b1);
		// enable, then a false start drops the lock
		set_rx_enable(1'b1);
		tick(1'b1);
		tick(1'b0);
		tick(1'b1);
		tick(1'b1);
		tick(1'b1);
		// extreme bytes, start sending, abort mid-byte
		write_byte(8'h00);
		write_byte(8'hFF);
		tick(1'b1);
		tick(1'b1);
		host(KIND_ABORT_TX);
		for (int i = 0; i < 4; i++)
			issue(KIND_CLR_FLAG, 1'($urandom), byte_t'($urandom), 1'($urandom), flag_idx_t'(i));
		set_rx_enable(1'b0);

		// no idling; long receiver hold-off while the transmit store overflows
		hold_len = 400;
		repeat (DEPTH + 2) write_byte(byte_t'($urandom));
		fill_rx_store();
		random_mix(PHASE_ITEMS);

		send_idle_pct = 86;
		stall_pct = 0;
		random_mix(PHASE_ITEMS);

		send_idle_pct = 0;
		stall_pct = 86;
		random_mix(PHASE_ITEMS);

		send_idle_pct = 7;
		stall_pct = 7;
		random_mix(PHASE_ITEMS);

		// drain outstanding status words
		req_ch.valid <= 1'b0;
		stall_pct = 0;
		while (sb.status_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/ovs_uart_pkg.sv
src/ovs_uart_if.sv
src/ovs_uart_ram.sv
src/oversampled_uart_transceiver.sv
dv/tb_uart_sb_pkg.sv
dv/tb_top.sv
